>>> hw/rtl/v3galu_pkg.sv
// Package for the three-component vector unit: opcodes, status codes and
// the side-band record that travels down the pipeline. No dependencies.
`default_nettype none

package v3galu_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_SCALE   = 4'd2,
    OP_MUL     = 4'd3,
    OP_DIV     = 4'd4,
    OP_LENGTH  = 4'd5,
    OP_NORM    = 4'd6,
    OP_DOT     = 4'd7,
    OP_CROSS   = 4'd8,
    OP_LERP    = 4'd9,
    OP_CLAMP   = 4'd10,
    OP_PROJECT = 4'd11
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_LERP    = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  // Per-request record carried alongside the arithmetic stages.
  typedef struct packed {
    op_t              kind;
    logic             sat;
    logic             lerp_bad;
    logic             dz;
    logic [2:0][31:0] r;
    logic [2:0]       num_neg;
    logic [2:0][31:0] num_mag;
    logic             den_neg;
    logic [31:0]      den_mag;
  } side_t;

endpackage

`default_nettype wire

>>> hw/rtl/vector3_geometry_alu_top.sv
// Vector unit top level: operand selection, multipliers, square-root and
// divider pipelines. Depends on v3galu_pkg.
`default_nettype none

// Fully pipelined Q(31-FRAC_BITS).FRAC_BITS vector unit (Q15.16 at
// FRAC_BITS = 16). One request is accepted every cycle while the output is
// not held. The pipeline is five front stages for operand selection,
// products and sums, a 32-stage square-root pipeline (one result bit per
// stage), one stage to set up the divisor, a 32 + FRAC_BITS stage restoring
// divider (one quotient bit per stage, three lanes), and the output register.
// Every request passes through all stages whatever its opcode. The whole
// pipeline advances together and holds while a result waits at the output.
module vector3_geometry_alu_top
  import v3galu_pkg::*;
#(
  parameter int COMPONENTS = 3,
  parameter int FRAC_BITS  = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_ready,
  input  wire  [3:0]        kind,
  input  wire  signed [31:0] a_x,
  input  wire  signed [31:0] a_y,
  input  wire  signed [31:0] a_z,
  input  wire  signed [31:0] a_w,
  input  wire  signed [31:0] b_x,
  input  wire  signed [31:0] b_y,
  input  wire  signed [31:0] b_z,
  input  wire  signed [31:0] scalar_in,
  output logic              res_valid,
  input  wire               res_ready,
  output logic signed [31:0] r_x,
  output logic signed [31:0] r_y,
  output logic signed [31:0] r_z,
  output logic signed [31:0] r_scalar,
  output logic [1:0]        status
);

  localparam int QW = 32 + FRAC_BITS;
  localparam logic signed [32:0] ONE  = 33'(64'd1 << FRAC_BITS);
  localparam logic signed [68:0] SMAX = 69'sd2147483647;
  localparam logic signed [68:0] SMIN = -69'sd2147483648;

  typedef struct packed {
    logic                valid;
    side_t               sd;
    logic [31:0]         rs;
    logic [63:0]         sq_x;
    logic [33:0]         sq_rem;
    logic [31:0]         sq_root;
    logic [2:0][32:0]    dv_rem;
    logic [2:0][QW-1:0]  dv_q;
  } pipe_t;

  // Returns {saturated, value} for a signed value clamped to 32 bits.
  function automatic logic [32:0] sat69(input logic signed [68:0] v);
    logic [32:0] res;
    if (v > SMAX) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v < SMIN) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  logic en;
  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  // ---------------- stage 1: request register ----------------
  logic               s1_valid;
  op_t                s1_kind;
  logic signed [31:0] s1_a [3];
  logic signed [31:0] s1_b [3];
  logic signed [31:0] s1_w;
  logic signed [31:0] s1_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req_valid;
    end
    if (en) begin
      s1_kind <= op_t'(kind);
      s1_a[0] <= a_x;
      s1_a[1] <= a_y;
      s1_a[2] <= (COMPONENTS == 2) ? 32'sd0 : a_z;
      s1_b[0] <= b_x;
      s1_b[1] <= b_y;
      s1_b[2] <= (COMPONENTS == 2) ? 32'sd0 : b_z;
      s1_w    <= a_w;
      s1_s    <= scalar_in;
    end
  end

  // ---------------- stage 2: operand selection ----------------
  logic signed [32:0] ea [3];
  logic signed [32:0] eb [3];
  logic signed [32:0] es, omt;
  logic signed [32:0] mu_n [3], mv_n [3], mw_n [3], mx_n [3];
  logic [31:0]        dr_n [3];
  logic [2:0]         dsat_n;
  side_t              s2_sd_n;
  logic signed [31:0] den;

  assign es  = {s1_s[31], s1_s};
  assign omt = ONE - es;

  for (genvar i = 0; i < 3; i++) begin : g_lane2
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic [32:0] add_sat, sub_sat;

    assign ea[i]   = {s1_a[i][31], s1_a[i]};
    assign eb[i]   = {s1_b[i][31], s1_b[i]};
    assign add_sat = sat69(69'(ea[i] + eb[i]));
    assign sub_sat = sat69(69'(ea[i] - eb[i]));

    always_comb begin
      mu_n[i]   = '0;
      mv_n[i]   = '0;
      mw_n[i]   = '0;
      mx_n[i]   = '0;
      dr_n[i]   = '0;
      dsat_n[i] = 1'b0;
      case (s1_kind) inside
        OP_ADD: begin
          dr_n[i]   = add_sat[31:0];
          dsat_n[i] = add_sat[32];
        end
        OP_SUB: begin
          dr_n[i]   = sub_sat[31:0];
          dsat_n[i] = sub_sat[32];
        end
        OP_SCALE: begin
          mu_n[i] = ea[i];
          mv_n[i] = es;
        end
        OP_MUL, OP_DOT: begin
          mu_n[i] = ea[i];
          mv_n[i] = eb[i];
        end
        OP_LENGTH, OP_NORM: begin
          mu_n[i] = ea[i];
          mv_n[i] = ea[i];
        end
        OP_CROSS: begin
          mu_n[i] = ea[J];
          mv_n[i] = eb[K];
          mw_n[i] = ea[K];
          mx_n[i] = eb[J];
        end
        OP_LERP: begin
          mu_n[i] = ea[i];
          mv_n[i] = omt;
          mw_n[i] = eb[i];
          mx_n[i] = es;
        end
        OP_CLAMP: begin
          if (ea[i] < 0) begin
            dr_n[i] = '0;
          end else if (ea[i] > ONE) begin
            dr_n[i] = ONE[31:0];
          end else begin
            dr_n[i] = s1_a[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    den = (s1_kind == OP_DIV) ? s1_s : s1_w;
    s2_sd_n          = '0;
    s2_sd_n.kind     = s1_kind;
    s2_sd_n.sat      = |dsat_n;
    s2_sd_n.lerp_bad = (s1_kind == OP_LERP) && ((es < 0) || (es > ONE));
    s2_sd_n.dz       = ((s1_kind == OP_DIV) || (s1_kind == OP_PROJECT)) && (den == 0);
    s2_sd_n.den_neg  = den[31];
    s2_sd_n.den_mag  = den[31] ? 32'(-den) : den;
    for (int i = 0; i < 3; i++) begin
      s2_sd_n.r[i]       = dr_n[i];
      s2_sd_n.num_neg[i] = s1_a[i][31];
      s2_sd_n.num_mag[i] = s1_a[i][31] ? 32'(-s1_a[i]) : s1_a[i];
    end
  end

  logic               s2_valid;
  side_t              s2_sd;
  logic signed [32:0] s2_u [3], s2_v [3], s2_w [3], s2_x [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_sd <= s2_sd_n;
      s2_u  <= mu_n;
      s2_v  <= mv_n;
      s2_w  <= mw_n;
      s2_x  <= mx_n;
    end
  end

  // ---------------- stage 3: products ----------------
  logic               s3_valid;
  side_t              s3_sd;
  logic signed [65:0] s3_p [3], s3_q [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_sd <= s2_sd;
      for (int i = 0; i < 3; i++) begin
        s3_p[i] <= 66'(s2_u[i]) * 66'(s2_v[i]);
        s3_q[i] <= 66'(s2_w[i]) * 66'(s2_x[i]);
      end
    end
  end

  // ---------------- stage 4: floor shift and lane combine ----------------
  logic signed [66:0] val_n [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane4
    logic signed [66:0] pe, qe, dif;
    assign pe  = 67'(s3_p[i]);
    assign qe  = 67'(s3_q[i]);
    assign dif = pe - qe;
    always_comb begin
      case (s3_sd.kind)
        OP_CROSS: val_n[i] = dif >>> FRAC_BITS;
        OP_LERP:  val_n[i] = (pe >>> FRAC_BITS) + (qe >>> FRAC_BITS);
        default:  val_n[i] = pe >>> FRAC_BITS;
      endcase
    end
  end

  logic               s4_valid;
  side_t              s4_sd;
  logic signed [66:0] s4_val [3];
  logic [63:0]        s4_sumsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
    if (en) begin
      s4_sd    <= s3_sd;
      s4_val   <= val_n;
      s4_sumsq <= s3_p[0][63:0] + s3_p[1][63:0] + s3_p[2][63:0];
    end
  end

  // ---------------- stage 5: dot sum and saturation ----------------
  pipe_t sq_pipe [0:32];
  pipe_t s5_n;

  always_comb begin
    logic signed [68:0] acc;
    logic [32:0]        st;
    acc = 69'(s4_val[0]) + 69'(s4_val[1]) + 69'(s4_val[2]);
    st  = '0;
    s5_n       = '0;
    s5_n.valid = s4_valid;
    s5_n.sd    = s4_sd;
    s5_n.sq_x  = s4_sumsq;
    case (s4_sd.kind) inside
      OP_SCALE, OP_MUL, OP_CROSS, OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          st = sat69(69'(s4_val[i]));
          s5_n.sd.r[i] = st[31:0];
          s5_n.sd.sat  = s5_n.sd.sat | st[32];
        end
      end
      OP_DOT: begin
        st = sat69(acc);
        s5_n.rs     = st[31:0];
        s5_n.sd.sat = st[32];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_pipe[0].valid <= 1'b0;
    end else if (en) begin
      sq_pipe[0] <= s5_n;
    end
  end

  // ---------------- square root: one result bit per stage ----------------
  for (genvar t = 0; t < 32; t++) begin : g_sqrt
    logic [35:0] cur, trial;
    pipe_t       nxt;

    assign cur   = {sq_pipe[t].sq_rem, sq_pipe[t].sq_x[63:62]};
    assign trial = {2'b00, sq_pipe[t].sq_root, 2'b01};

    always_comb begin
      nxt      = sq_pipe[t];
      nxt.sq_x = {sq_pipe[t].sq_x[61:0], 2'b00};
      if (cur >= trial) begin
        nxt.sq_rem  = 34'(cur - trial);
        nxt.sq_root = {sq_pipe[t].sq_root[30:0], 1'b1};
      end else begin
        nxt.sq_rem  = cur[33:0];
        nxt.sq_root = {sq_pipe[t].sq_root[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_pipe[t+1].valid <= 1'b0;
      end else if (en) begin
        sq_pipe[t+1] <= nxt;
      end
    end
  end

  // ---------------- divisor set-up after the square root ----------------
  pipe_t dv_pipe [0:QW];
  pipe_t dset_n;

  always_comb begin
    logic [32:0] st;
    st     = sat69(69'({1'b0, sq_pipe[32].sq_root}));
    dset_n = sq_pipe[32];
    dset_n.dv_rem = '0;
    dset_n.dv_q   = '0;
    case (sq_pipe[32].sd.kind)
      OP_LENGTH: begin
        dset_n.rs     = st[31:0];
        dset_n.sd.sat = st[32];
      end
      OP_NORM: begin
        dset_n.sd.den_neg = 1'b0;
        dset_n.sd.den_mag = sq_pipe[32].sq_root;
        dset_n.sd.dz      = (sq_pipe[32].sq_root == 32'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_pipe[0].valid <= 1'b0;
    end else if (en) begin
      dv_pipe[0] <= dset_n;
    end
  end

  // ---------------- restoring divider: one quotient bit per stage ----------------
  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int NB = QW - 1 - t;
    pipe_t nxt;
    logic [32:0] cur [3];
    logic [32:0] dd;

    assign dd = {1'b0, dv_pipe[t].sd.den_mag};

    for (genvar l = 0; l < 3; l++) begin : g_l
      logic nbit;
      if (NB >= FRAC_BITS) begin : g_num
        assign nbit = dv_pipe[t].sd.num_mag[l][NB-FRAC_BITS];
      end else begin : g_zero
        assign nbit = 1'b0;
      end
      assign cur[l] = {dv_pipe[t].dv_rem[l][31:0], nbit};
    end

    always_comb begin
      nxt = dv_pipe[t];
      for (int l = 0; l < 3; l++) begin
        if (cur[l] >= dd) begin
          nxt.dv_rem[l] = cur[l] - dd;
          nxt.dv_q[l]   = {dv_pipe[t].dv_q[l][QW-2:0], 1'b1};
        end else begin
          nxt.dv_rem[l] = cur[l];
          nxt.dv_q[l]   = {dv_pipe[t].dv_q[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_pipe[t+1].valid <= 1'b0;
      end else if (en) begin
        dv_pipe[t+1] <= nxt;
      end
    end
  end

  // ---------------- final sign, saturation and status ----------------
  pipe_t              fin;
  logic [31:0]        fr [3];
  logic [31:0]        frs;
  logic               fsat;
  logic [1:0]         fst;

  assign fin = dv_pipe[QW];

  always_comb begin
    logic neg;
    logic [QW-1:0] q;
    neg  = 1'b0;
    q    = '0;
    fsat = fin.sd.sat;
    frs  = fin.rs;
    for (int l = 0; l < 3; l++) begin
      fr[l] = fin.sd.r[l];
    end
    case (fin.sd.kind) inside
      OP_DIV, OP_PROJECT, OP_NORM: begin
        for (int l = 0; l < 3; l++) begin
          neg = fin.sd.num_neg[l] ^ fin.sd.den_neg;
          q   = fin.dv_q[l];
          if (neg) begin
            if (q > QW'(33'h0_8000_0000)) begin
              fr[l] = 32'h8000_0000;
              fsat  = 1'b1;
            end else begin
              fr[l] = 32'(-q);
            end
          end else begin
            if (q > QW'(32'h7fff_ffff)) begin
              fr[l] = 32'h7fff_ffff;
              fsat  = 1'b1;
            end else begin
              fr[l] = q[31:0];
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (fin.sd.dz) begin
      for (int l = 0; l < 3; l++) begin
        fr[l] = '0;
      end
      frs = '0;
      fst = ST_DIVZERO;
    end else if (fsat) begin
      fst = ST_SAT;
    end else if (fin.sd.lerp_bad) begin
      fst = ST_LERP;
    end else begin
      fst = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= fin.valid;
    end
    if (en) begin
      r_x      <= fr[0];
      r_y      <= fr[1];
      r_z      <= fr[2];
      r_scalar <= frs;
      status   <= fst;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_vector3_geometry_alu_top.sv
// Self-checking bench for the three-component fixed-point vector unit.
// Drives requests through a queue-fed driver and checks every result against
// an in-bench prediction; depends on v3galu_pkg and vector3_geometry_alu_top.
`timescale 1ns / 1ps

module tb_vector3_geometry_alu_top;
  import v3galu_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam int PHASE_ITEMS = 470;

  typedef struct {
    logic [3:0]         kind;
    logic signed [31:0] ax, ay, az, aw, bx, by, bz, s;
  } vec_req_t;

  typedef struct {
    logic signed [31:0] rx, ry, rz, rs;
    logic [1:0]         status;
  } vec_res_t;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  logic [3:0] kind = 0;
  logic signed [31:0] a_x = 0, a_y = 0, a_z = 0, a_w = 0;
  logic signed [31:0] b_x = 0, b_y = 0, b_z = 0, scalar_in = 0;
  logic res_valid;
  logic res_ready = 0;
  logic signed [31:0] r_x, r_y, r_z, r_scalar;
  logic [1:0] status;

  vec_req_t pending_reqs[$];
  vec_res_t expected_res[$];
  vec_req_t cur;
  int send_idle = 0;
  int recv_stall = 0;
  int mismatches = 0;
  logic hold_start = 0;
  int hold_cnt = 0;

  vector3_geometry_alu_top DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .kind(kind),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .scalar_in(scalar_in),
    .res_valid(res_valid), .res_ready(res_ready),
    .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_scalar(r_scalar), .status(status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint clip32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Quotient in fixed point, truncated toward zero, saturating.
  function automatic longint fix_quot(longint num, longint den, inout bit sat);
    longint unsigned q;
    q = (mag(num) << FRAC) / mag(den);
    if ((num < 0) != (den < 0)) begin
      if (q > 64'h8000_0000) begin
        sat = 1;
        return -64'sd2147483648;
      end
      return -longint'(q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1;
      return 64'sd2147483647;
    end
    return longint'(q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic vec_res_t vector_result(vec_req_t q);
    longint a[3], b[3], r[3], rs, d, acc, omt, s;
    longint unsigned len;
    bit sat, dz, lerp_bad;
    vec_res_t o;
    a = '{longint'(q.ax), longint'(q.ay), longint'(q.az)};
    b = '{longint'(q.bx), longint'(q.by), longint'(q.bz)};
    r = '{0, 0, 0};
    s = q.s;
    rs = 0;
    sat = 0;
    dz = 0;
    lerp_bad = 0;
    case (q.kind)
      OP_ADD: for (int i = 0; i < 3; i++) r[i] = clip32(a[i] + b[i], sat);
      OP_SUB: for (int i = 0; i < 3; i++) r[i] = clip32(a[i] - b[i], sat);
      OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clip32((a[i] * s) >>> FRAC, sat);
      OP_MUL: for (int i = 0; i < 3; i++) r[i] = clip32((a[i] * b[i]) >>> FRAC, sat);
      OP_DIV, OP_PROJECT: begin
        d = (q.kind == OP_DIV) ? s : longint'(q.aw);
        if (d == 0) dz = 1;
        else for (int i = 0; i < 3; i++) r[i] = fix_quot(a[i], d, sat);
      end
      OP_LENGTH, OP_NORM: begin
        len = root_floor(mag(a[0]) * mag(a[0]) + mag(a[1]) * mag(a[1])
                         + mag(a[2]) * mag(a[2]));
        if (q.kind == OP_LENGTH) rs = clip32(longint'(len), sat);
        else if (len == 0) dz = 1;
        else for (int i = 0; i < 3; i++) r[i] = fix_quot(a[i], longint'(len), sat);
      end
      OP_DOT: begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc += (a[i] * b[i]) >>> FRAC;
        rs = clip32(acc, sat);
      end
      OP_CROSS:
        for (int i = 0; i < 3; i++)
          r[i] = clip32((a[(i + 1) % 3] * b[(i + 2) % 3]
                         - a[(i + 2) % 3] * b[(i + 1) % 3]) >>> FRAC, sat);
      OP_LERP: begin
        omt = ONE - s;
        lerp_bad = (s < 0) || (s > ONE);
        for (int i = 0; i < 3; i++)
          r[i] = clip32(((a[i] * omt) >>> FRAC) + ((b[i] * s) >>> FRAC), sat);
      end
      OP_CLAMP:
        for (int i = 0; i < 3; i++) r[i] = a[i] < 0 ? 0 : (a[i] > ONE ? ONE : a[i]);
      default: ;
    endcase
    if (dz) begin
      r = '{0, 0, 0};
      rs = 0;
      o.status = ST_DIVZERO;
    end else if (sat) o.status = ST_SAT;
    else if (lerp_bad) o.status = ST_LERP;
    else o.status = ST_OK;
    o.rx = r[0][31:0];
    o.ry = r[1][31:0];
    o.rz = r[2][31:0];
    o.rs = rs[31:0];
    return o;
  endfunction

  // Operand mix: full range, small magnitudes and the awkward corners.
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2, 3: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
      4: return $signed($urandom_range(32'h0000_4000)) - 32'sh0000_2000;
      default: begin
        case ($urandom_range(5))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 0;
          3: return 32'sh0001_0000;
          4: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  task automatic add_request(logic [3:0] k, logic signed [31:0] ax, ay, az, aw,
                             bx, by, bz, s);
    vec_req_t q;
    q.kind = k;
    q.ax = ax; q.ay = ay; q.az = az; q.aw = aw;
    q.bx = bx; q.by = by; q.bz = bz; q.s = s;
    pending_reqs.push_back(q);
  endtask

  task automatic add_random(int n);
    logic [3:0] k;
    logic signed [31:0] s, aw;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
      s = pick_operand();
      aw = pick_operand();
      // Lerp fractions mostly inside [0, 1.0].
      if (k == OP_LERP && $urandom_range(3) != 0) s = $urandom_range(32'h0001_0000);
      if (k == OP_DIV && $urandom_range(19) == 0) s = 0;
      if (k == OP_PROJECT && $urandom_range(19) == 0) aw = 0;
      add_request(k, pick_operand(), pick_operand(), pick_operand(), aw,
                  pick_operand(), pick_operand(), pick_operand(), s);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_res.size() != 0);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 0;
    end else begin
      if (req_valid && req_ready) expected_res.push_back(vector_result(cur));
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur = pending_reqs.pop_front();
          kind <= cur.kind;
          a_x <= cur.ax; a_y <= cur.ay; a_z <= cur.az; a_w <= cur.aw;
          b_x <= cur.bx; b_y <= cur.by; b_z <= cur.bz; scalar_in <= cur.s;
          req_valid <= 1;
        end else begin
          req_valid <= 0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    vec_res_t e;
    if (rst) begin
      res_ready <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          e = expected_res.pop_front();
          if (r_x !== e.rx || r_y !== e.ry || r_z !== e.rz || r_scalar !== e.rs ||
              status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h %h %h %h st %0d, got %h %h %h %h st %0d",
                       e.rx, e.ry, e.rz, e.rs, e.status,
                       r_x, r_y, r_z, r_scalar, status);
          end
        end
      end
      if (hold_start) begin
        hold_cnt <= 400;
        res_ready <= 0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        res_ready <= 0;
      end else begin
        res_ready <= $urandom_range(99) >= recv_stall;
      end
    end
  end

  initial begin
    logic signed [31:0] mx, mn, one32;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    one32 = 32'sh0001_0000;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: every opcode, the corners, and each special case.
    add_request(OP_ADD, mx, mn, 1, 0, 1, -1, 2, 0);
    add_request(OP_SUB, mn, mx, 5, 0, 1, -1, 3, 0);
    add_request(OP_SCALE, mx, mn, -one32, 0, 0, 0, 0, mx);
    add_request(OP_SCALE, -3, 3, one32, 0, 0, 0, 0, one32 / 2);
    add_request(OP_MUL, mn, -5, mx, 0, mn, 7, mx, 0);
    add_request(OP_DIV, one32, -one32, 7, 0, 0, 0, 0, 0);
    add_request(OP_DIV, mx, mn, mn, 0, 0, 0, 0, -one32);
    add_request(OP_DIV, mx, -one32, 3, 0, 0, 0, 0, 1);
    add_request(OP_LENGTH, mn, mn, mn, 0, 0, 0, 0, 0);
    add_request(OP_LENGTH, 3 * one32, 4 * one32, 0, 0, 0, 0, 0, 0);
    add_request(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(OP_NORM, 0, -one32, 0, 0, 0, 0, 0, 0);
    add_request(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
    add_request(OP_DOT, mx, mn, mx, 0, mx, mn, mx, 0);
    add_request(OP_DOT, one32, 2 * one32, -one32, 0, 3, -4, 5, 0);
    add_request(OP_CROSS, one32, 0, 0, 0, 0, one32, 0, 0);
    add_request(OP_CROSS, mn, mx, mn, 0, mx, mn, mn, 0);
    add_request(OP_LERP, one32, 2 * one32, mn, 0, -one32, 0, mx, one32 / 4);
    add_request(OP_LERP, one32, -one32, 0, 0, 0, 0, 0, -1);
    add_request(OP_LERP, mx, mn, 0, 0, mn, mx, 0, one32 + 1);
    add_request(OP_CLAMP, -1, one32 + 1, one32 / 2, 0, 0, 0, 0, 0);
    add_request(OP_PROJECT, one32, mn, mx, 0, 0, 0, 0, 0);
    add_request(OP_PROJECT, mx, mn, one32, 1, 0, 0, 0, 0);
    add_request(4'd12, mx, mx, mx, mx, mx, mx, mx, mx);
    add_request(4'd15, -1, -1, -1, -1, -1, -1, -1, -1);

    // Back-to-back phase with a long receiver hold-off to fill the pipeline.
    add_random(PHASE_ITEMS);
    @(negedge clk);
    hold_start = 1;
    @(negedge clk);
    hold_start = 0;
    wait_drained();

    send_idle = 57;
    recv_stall = 0;
    add_random(PHASE_ITEMS);
    wait_drained();

    send_idle = 0;
    recv_stall = 57;
    add_random(PHASE_ITEMS);
    wait_drained();

    send_idle = 25;
    recv_stall = 25;
    add_random(PHASE_ITEMS);
    wait_drained();

    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
